// ===== rtl/sha256_block_hasher_core_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-256 block hasher assertion macros
// Property wrappers for the checker file of the hasher core.
// ----------------------------------------------------------------------------
`ifndef SHA256_BLOCK_HASHER_CORE_DEFINES_SVH
`define SHA256_BLOCK_HASHER_CORE_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define SHBH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a condition in the cycle after its trigger
`define SHBH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/shbh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block hasher package
// Types, constants and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package shbh_pkg;

	localparam int unsigned WordW = 32;
	localparam logic [2:0] LastIdx = 3'd7;
	localparam logic [3:0] LastWord = 4'd15;
	localparam logic [5:0] LastRound = 6'd63;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		logic word_load;
		logic chain_init;
		logic vars_load;
		logic round_en;
		logic chain_add;
	} shbh_ctl_t;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FINAL = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t init_hash(input logic [2:0] i);
		word_t v;
		case (i)
			3'd0: v = 32'h6a09e667;
			3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372;
			3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f;
			3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_block_hasher_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block hasher core
// Takes padded message beats sixteen to a block and emits the digest
// after a block flagged final.
// ----------------------------------------------------------------------------
// The core accepts the sixteen words of a block on consecutive cycles, then
// stalls its input while a single round unit runs the 64 rounds, one per
// cycle, and a final state adds the working variables into the chaining
// value. After a block flagged final the eight digest beats follow, one per
// cycle unless the output stalls, before the next block can start.
`default_nettype none

module sha256_block_hasher_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [31:0] message_word,
	input  wire         first_block,
	input  wire         final_block,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_last
);
	import shbh_pkg::*;

	state_t     state_q;
	logic [3:0] word_q;
	logic [5:0] round_q;
	logic [2:0] idx_q;
	logic       final_q;
	logic       in_accept;
	logic       out_accept;
	shbh_ctl_t  ctl;
	word_t      sched_w;

	assign in_stall   = (state_q != ST_LOAD);
	assign in_accept  = in_valid && !in_stall;
	assign out_valid  = (state_q == ST_EMIT);
	assign out_accept = out_valid && !out_stall;

	assign ctl.word_load  = in_accept;
	assign ctl.chain_init = in_accept && (word_q == '0) && first_block;
	assign ctl.vars_load  = in_accept && (word_q == LastWord);
	assign ctl.round_en   = (state_q == ST_ROUND);
	assign ctl.chain_add  = (state_q == ST_FINAL);

	assign digest_index = idx_q;
	assign digest_last  = (idx_q == LastIdx);

	shbh_sched u_sched (
		.clk          (clk),
		.ctl          (ctl),
		.message_word (message_word),
		.sched_w      (sched_w)
	);

	shbh_compress u_compress (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sched_w   (sched_w),
		.round_idx (round_q),
		.rd_idx    (idx_q),
		.rd_word   (digest_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			word_q  <= '0;
			round_q <= '0;
			idx_q   <= '0;
			final_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_accept) begin
						word_q <= word_q + 4'd1;
						if (word_q == LastWord) begin
							final_q <= final_block;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == LastRound) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					idx_q   <= '0;
					state_q <= final_q ? ST_EMIT : ST_LOAD;
				end
				ST_EMIT: begin
					if (out_accept) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == LastIdx) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/shbh_sched.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word sliding window: loads message beats, then expands one word
// per round and presents the current schedule word.
// ----------------------------------------------------------------------------
`default_nettype none

module shbh_sched (
	input  wire                 clk,
	input  shbh_pkg::shbh_ctl_t ctl,
	input  shbh_pkg::word_t     message_word,
	output shbh_pkg::word_t     sched_w
);
	import shbh_pkg::*;

	word_t win_q [16];
	word_t next_w;

	assign next_w = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
	assign sched_w = win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.word_load || ctl.round_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= ctl.word_load ? message_word : next_w;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/shbh_compress.sv =====
// ----------------------------------------------------------------------------
// SHA-256 compression datapath
// Working variables with one shared round unit, and the chaining value with
// its feed-forward add and digest read port.
// ----------------------------------------------------------------------------
`default_nettype none

module shbh_compress (
	input  wire                 clk,
	input  wire                 arst_n,
	input  shbh_pkg::shbh_ctl_t ctl,
	input  shbh_pkg::word_t     sched_w,
	input  wire  [5:0]          round_idx,
	input  wire  [2:0]          rd_idx,
	output shbh_pkg::word_t     rd_word
);
	import shbh_pkg::*;

	word_t chain_q [8];
	word_t var_q [8];
	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	assign ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign t1  = var_q[7] + big_sigma1(var_q[4]) + ch + round_k(round_idx) + sched_w;
	assign t2  = big_sigma0(var_q[0]) + maj;
	assign rd_word = chain_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= init_hash(3'(i));
			end
		end else if (ctl.chain_init) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= init_hash(3'(i));
			end
		end else if (ctl.chain_add) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + var_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vars_load) begin
			for (int i = 0; i < 8; i++) begin
				var_q[i] <= chain_q[i];
			end
		end else if (ctl.round_en) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/shbh_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block hasher port checker
// Port-level properties of the digest sequence, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_block_hasher_core_defines.svh"

module shbh_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [31:0] digest_word,
	input wire [2:0]  digest_index,
	input wire        digest_last
);

	`SHBH_ASSERT_SAME(a_no_input_while_emit, out_valid, in_stall, "input taken during digest")
	`SHBH_ASSERT_SAME(a_first_index_zero, $rose(out_valid), digest_index == 3'd0, "digest does not start at word 0")
	`SHBH_ASSERT_NEXT(a_index_advance, out_valid && !out_stall && !digest_last, out_valid && digest_index == $past(digest_index) + 3'd1, "digest index skipped")
	`SHBH_ASSERT_NEXT(a_end_after_last, out_valid && !out_stall && digest_last, !out_valid, "digest runs past last word")
	`SHBH_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(digest_word), "stalled digest beat changed")

endmodule

bind sha256_block_hasher_core shbh_checker u_shbh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.digest_word  (digest_word),
	.digest_index (digest_index),
	.digest_last  (digest_last)
);

`default_nettype wire
